// ----- src/irbp_pkg.sv -----
// package for the image resource block parser
// status codes, constants and the result record shared by the engine, top level and testbench
package irbp_pkg;

  localparam logic [31:0] SigWord = 32'h3842494D;
  localparam logic [16:0] MaxCountReset = 17'h10000;
  localparam logic [31:0] MaxBlockReset = 32'h0400_0000;
  localparam logic [31:0] MaxSingleReset = 32'h0200_0000;
  localparam int unsigned DefLengthWidth = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_LIMIT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_MAX_COUNT = 2'd0,
    REG_MAX_BLOCK = 2'd1,
    REG_MAX_SINGLE = 2'd2
  } reg_idx_e;

  // one byte transaction passed from the front part to the back part
  typedef struct packed {
    logic        block_start;
    logic [7:0]  in_byte;
    logic [31:0] block_size;
  } item_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  out_byte;
    logic [15:0] rsrc_id;
    logic [15:0] resource_index;
    logic [31:0] byte_offset;
    logic        resource_end;
    logic        block_done;
    logic [1:0]  status;
    logic [16:0] resources_done;
  } result_t;

endpackage

// ----- src/irbp_fifo.sv -----
// small register queue used between stages and at the result side
// depends on irbp_pkg only through the caller's type width
module irbp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  logic [Width-1:0] mem_q [Depth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Aw:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == Aw'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (do_pop) rd_q <= (rd_q == Aw'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end
endmodule

// ----- src/irbp_engine.sv -----
// back part: resource field state machine, limits and result generation
// depends on irbp_pkg
module irbp_engine import irbp_pkg::*; #(
  parameter int unsigned LengthWidth = DefLengthWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic        ready_o,
  output logic        res_valid_o,
  output result_t     res_o,
  input  logic        res_full_i,
  input  logic [16:0] max_count_i,
  input  logic [31:0] max_block_i,
  input  logic [31:0] max_single_i
);
  typedef enum logic [3:0] {
    PH_IDLE, PH_NEXT, PH_SIG, PH_TRAIL, PH_SKIP, PH_ID, PH_NAMELEN,
    PH_NAME, PH_LEN, PH_DATA, PH_PAD
  } phase_e;

  phase_e phase_q, phase_d;
  logic [31:0] pos_q, pos_d, size_q, size_d, left_q, left_d, len_q, len_d;
  logic [31:0] off_q, off_d, sig_q, sig_d;
  logic [15:0] id_q, id_d;
  logic [16:0] cnt_q, cnt_d;
  logic [32:0] tot_q, tot_d;
  logic zero_q, zero_d;

  logic go, last, emit;
  result_t r;
  logic [7:0] b;
  logic [31:0] rem, len_new, name_tot;
  logic [32:0] padded, tot_new;

  assign ready_o = !res_full_i;
  assign go = valid_i && ready_o;
  assign b = item_i.in_byte;
  assign res_valid_o = go && emit;
  assign res_o = r;

  always_comb begin
    phase_d = phase_q; pos_d = pos_q; size_d = size_q; left_d = left_q;
    len_d = len_q; off_d = off_q; sig_d = sig_q; id_d = id_q;
    cnt_d = cnt_q; tot_d = tot_q; zero_d = zero_q;
    emit = 1'b0;
    r = '0;
    last = 1'b0;
    rem = '0; len_new = '0; name_tot = '0; padded = '0; tot_new = '0;
    if (item_i.block_start) begin
      size_d = item_i.block_size;
      pos_d = '0; left_d = 32'd4; id_d = '0; len_d = '0; off_d = '0;
      cnt_d = '0; tot_d = '0; sig_d = '0; zero_d = 1'b1;
      phase_d = PH_SIG;
    end else begin
      pos_d = pos_q + 32'd1;
    end
    last = pos_d >= size_d - 32'd1;
    rem = size_d - pos_d;
    if (item_i.block_start && item_i.block_size < 32'd4) begin
      emit = 1'b1; r.block_done = 1'b1; r.status = ST_UNSUPPORTED;
      phase_d = PH_IDLE;
    end else if (!item_i.block_start && phase_q == PH_IDLE) begin
      pos_d = pos_q;
    end else begin
      if (phase_d == PH_NEXT) begin
        if (cnt_d >= max_count_i) begin
          emit = 1'b1; r.block_done = 1'b1; r.status = ST_LIMIT;
          phase_d = PH_IDLE;
        end else if (rem < 32'd4) begin
          if (last) begin
            emit = 1'b1; r.block_done = 1'b1; r.status = ST_OK;
            phase_d = PH_IDLE;
          end else phase_d = PH_SKIP;
        end else begin
          sig_d = '0; zero_d = 1'b1; left_d = 32'd4; phase_d = PH_SIG;
        end
      end
      if (!emit) begin
        case (phase_d)
          PH_SIG: begin
            if (!(phase_q == PH_NEXT && phase_d == PH_SKIP)) begin
              sig_d = {sig_d[23:0], b};
              if (b != 8'd0) zero_d = 1'b0;
              left_d = left_d - 32'd1;
              if (left_d == 32'd0) begin
                emit = 1'b1; r.block_done = 1'b1;
                if (pos_d == 32'd3 && sig_d != SigWord) r.status = ST_UNSUPPORTED;
                else if (pos_d == 32'd3 && max_block_i != '0 && size_d > max_block_i)
                  r.status = ST_LIMIT;
                else if (pos_d == 32'd3 && cnt_d >= max_count_i) r.status = ST_LIMIT;
                else if (pos_d != 32'd3 && sig_d != SigWord) begin
                  if (!zero_d) r.status = ST_MALFORMED;
                  else if (last) r.status = ST_OK;
                  else begin emit = 1'b0; r = '0; phase_d = PH_TRAIL; end
                end else if (last) r.status = ST_MALFORMED;
                else begin
                  emit = 1'b0; r = '0;
                  phase_d = PH_ID; left_d = 32'd2; id_d = '0;
                end
                if (emit) phase_d = PH_IDLE;
              end
            end
          end
          PH_TRAIL: begin
            if (b != 8'd0 || last) begin
              emit = 1'b1; r.block_done = 1'b1;
              r.status = (b != 8'd0) ? ST_MALFORMED : ST_OK;
              phase_d = PH_IDLE;
            end
          end
          PH_SKIP: begin
            if (phase_q == PH_SKIP && last) begin
              emit = 1'b1; r.block_done = 1'b1; r.status = ST_OK;
              phase_d = PH_IDLE;
            end
          end
          PH_ID: begin
            id_d = {id_q[7:0], b};
            left_d = left_q - 32'd1;
            if (last) begin
              emit = 1'b1; r.block_done = 1'b1; r.status = ST_MALFORMED;
              phase_d = PH_IDLE;
            end else if (left_d == 32'd0) phase_d = PH_NAMELEN;
          end
          PH_NAMELEN: begin
            name_tot = {23'd0, 9'({1'b0, b} + 9'd2) & 9'h1FE};
            if (name_tot > rem) begin
              emit = 1'b1; r.block_done = 1'b1; r.status = ST_MALFORMED;
              phase_d = PH_IDLE;
            end else begin
              left_d = name_tot - 32'd1; phase_d = PH_NAME;
            end
          end
          PH_NAME: begin
            left_d = left_q - 32'd1;
            if (last) begin
              emit = 1'b1; r.block_done = 1'b1; r.status = ST_MALFORMED;
              phase_d = PH_IDLE;
            end else if (left_d == 32'd0) begin
              phase_d = PH_LEN; left_d = 32'd4; len_d = '0;
            end
          end
          PH_LEN: begin
            len_new = {len_q[23:0], b};
            len_d = len_new;
            left_d = left_q - 32'd1;
            padded = ({1'b0, len_new} + 33'd1) & ~33'd1;
            tot_new = tot_q + {1'b0, len_new};
            if (left_d != 32'd0) begin
              if (last) begin
                emit = 1'b1; r.block_done = 1'b1; r.status = ST_MALFORMED;
                phase_d = PH_IDLE;
              end
            end else if (len_new > max_single_i) begin
              emit = 1'b1; r.block_done = 1'b1; r.status = ST_LIMIT;
              phase_d = PH_IDLE;
            end else if (padded > {1'b0, rem - 32'd1}) begin
              emit = 1'b1; r.block_done = 1'b1; r.status = ST_MALFORMED;
              phase_d = PH_IDLE;
            end else if ((max_block_i != '0 && tot_new > {1'b0, max_block_i}) ||
                         (LengthWidth < 32 && (len_new >> LengthWidth) != '0)) begin
              tot_d = tot_new;
              emit = 1'b1; r.block_done = 1'b1; r.status = ST_LIMIT;
              phase_d = PH_IDLE;
            end else begin
              tot_d = tot_new;
              if (len_new == '0) begin
                emit = 1'b1;
                r.rsrc_id = id_q; r.resource_index = cnt_q[15:0];
                r.resource_end = 1'b1; r.block_done = last; r.status = ST_OK;
                cnt_d = cnt_q + 17'd1;
                phase_d = last ? PH_IDLE : PH_NEXT;
              end else begin
                off_d = '0; phase_d = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            emit = 1'b1;
            r.data_valid = 1'b1; r.out_byte = b;
            r.rsrc_id = id_q; r.resource_index = cnt_q[15:0];
            r.byte_offset = off_q;
            r.resource_end = (off_q == len_q - 32'd1);
            r.block_done = last; r.status = ST_OK;
            if (r.resource_end) begin
              cnt_d = cnt_q + 17'd1;
              phase_d = len_q[0] ? PH_PAD : PH_NEXT;
            end
            off_d = off_q + 32'd1;
            if (last) phase_d = PH_IDLE;
          end
          PH_PAD: begin
            if (last) begin
              emit = 1'b1; r.block_done = 1'b1; r.status = ST_OK;
              phase_d = PH_IDLE;
            end else phase_d = PH_NEXT;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
    r.resources_done = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q <= '0; size_q <= '0; left_q <= '0; len_q <= '0; off_q <= '0;
      sig_q <= '0; id_q <= '0; cnt_q <= '0; tot_q <= '0; zero_q <= 1'b1;
    end else if (go) begin
      phase_q <= phase_d;
      pos_q <= pos_d; size_q <= size_d; left_q <= left_d; len_q <= len_d;
      off_q <= off_d; sig_q <= sig_d; id_q <= id_d; cnt_q <= cnt_d;
      tot_q <= tot_d; zero_q <= zero_d;
    end
  end
endmodule

// ----- src/image_resource_block_parser_unit.sv -----
// channel  | direction | handshake
// input    | in        | push / full
// result   | out       | pop / empty
// config   | in        | cfg_we_i, cfg_idx_i, cfg_data_i
// one byte per cycle sustained; the field state machine in the engine takes
// one byte each cycle while the result queue is not full. a two-entry queue
// separates intake from the engine and a two-entry queue holds results; a
// stalled pop backs up into full.
// reset clears control state and loads register defaults.
// top level: intake queue, parser engine, result queue; depends on irbp_pkg
module image_resource_block_parser_unit import irbp_pkg::*; #(
  parameter int unsigned LengthWidth = DefLengthWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        block_start_i,
  input  logic [7:0]  in_byte_i,
  input  logic [31:0] block_size_i,
  output logic        empty,
  input  logic        pop,
  output logic        data_valid_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] rsrc_id_o,
  output logic [15:0] resource_index_o,
  output logic [31:0] byte_offset_o,
  output logic        resource_end_o,
  output logic        block_done_o,
  output logic [1:0]  status_o,
  output logic [16:0] resources_done_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  logic [16:0] max_count_q;
  logic [31:0] max_block_q, max_single_q;
  item_t in_item, q_item;
  logic q_empty, eng_ready, res_valid, res_full;
  result_t res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= MaxCountReset;
      max_block_q <= MaxBlockReset;
      max_single_q <= MaxSingleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_COUNT: max_count_q <= cfg_data_i[16:0];
        REG_MAX_BLOCK: max_block_q <= cfg_data_i;
        REG_MAX_SINGLE: max_single_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item = '{block_start: block_start_i, in_byte: in_byte_i,
                     block_size: block_size_i};

  irbp_fifo #(.Width($bits(item_t)), .Depth(QueueDepth)) u_in_q (
    .clk_i, .rst_ni, .push_i(push), .data_i(in_item), .full_o(full),
    .pop_i(eng_ready), .data_o(q_item), .empty_o(q_empty)
  );

  irbp_engine #(.LengthWidth(LengthWidth)) u_engine (
    .clk_i, .rst_ni, .valid_i(!q_empty), .item_i(q_item), .ready_o(eng_ready),
    .res_valid_o(res_valid), .res_o(res), .res_full_i(res_full),
    .max_count_i(max_count_q), .max_block_i(max_block_q),
    .max_single_i(max_single_q)
  );

  irbp_fifo #(.Width($bits(result_t)), .Depth(QueueDepth)) u_out_q (
    .clk_i, .rst_ni, .push_i(res_valid), .data_i(res), .full_o(res_full),
    .pop_i(pop), .data_o(out_res), .empty_o(empty)
  );

  assign data_valid_o = out_res.data_valid;
  assign out_byte_o = out_res.out_byte;
  assign rsrc_id_o = out_res.rsrc_id;
  assign resource_index_o = out_res.resource_index;
  assign byte_offset_o = out_res.byte_offset;
  assign resource_end_o = out_res.resource_end;
  assign block_done_o = out_res.block_done;
  assign status_o = out_res.status;
  assign resources_done_o = out_res.resources_done;

  a_status_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !block_done_o) |-> status_o == ST_OK) else $error("status without done");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !res_full) else $error("result lost");
  a_data_tagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !data_valid_o) |-> out_byte_o == 8'd0) else $error("stray byte");
endmodule

// ----- test/tb.sv -----
// testbench for image_resource_block_parser_unit: byte stream driver, result monitor
// and a cycle-free parser predictor checked field by field; depends on irbp_pkg
`timescale 1ns / 100ps

module tb import irbp_pkg::*;;

  typedef enum logic [3:0] {
    P_IDLE, P_NEXT, P_SIG, P_TRAIL, P_SKIP, P_ID, P_NAMELEN, P_NAME, P_LEN, P_DATA, P_PAD
  } parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        block_start_i = 1'b0;
  logic [7:0]  in_byte_i = '0;
  logic [31:0] block_size_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        data_valid_o, resource_end_o, block_done_o;
  logic [7:0]  out_byte_o;
  logic [15:0] rsrc_id_o, resource_index_o;
  logic [31:0] byte_offset_o;
  logic [1:0]  status_o;
  logic [16:0] resources_done_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_MAX_COUNT;
  logic [31:0] cfg_data_i = '0;

  item_t   pending_bytes[$];
  result_t expected_results[$];
  result_t seen;
  logic    taken = 1'b0;
  int      errors = 0;
  int      send_idle = 14;
  int      recv_idle = 80;
  int      hold_req = 0;
  int      hold_served = 0;
  int      hold_left = 0;
  int      stall_cycles = 0;

  // predictor state and register copies
  parse_phase_e ph = P_IDLE;
  logic [31:0] pos, sz, fl, lenh, doff, sigw;
  logic [15:0] idh;
  logic [16:0] rcnt;
  logic [63:0] tot;
  logic        zonly;
  logic [16:0] lim_count = MaxCountReset;
  logic [31:0] lim_block = MaxBlockReset;
  logic [31:0] lim_single = MaxSingleReset;

  image_resource_block_parser_unit DUT (.*);

  assign seen = {data_valid_o, out_byte_o, rsrc_id_o, resource_index_o, byte_offset_o,
                 resource_end_o, block_done_o, status_o, resources_done_o};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit close_block(status_e st, output result_t r);
    ph = P_IDLE;
    r = '0;
    r.block_done = 1'b1;
    r.status = st;
    r.resources_done = rcnt;
    return 1'b1;
  endfunction

  function automatic bit parse_byte(input item_t it, output result_t r);
    logic [7:0]  b;
    logic        lst;
    logic [8:0]  nt;
    logic [32:0] padded;
    logic [15:0] idx;
    logic [31:0] off;
    b = it.in_byte;
    r = '0;
    if (it.block_start) begin
      sz = it.block_size; pos = '0; fl = 32'd4; idh = '0; lenh = '0; doff = '0;
      rcnt = '0; tot = '0; sigw = '0; zonly = 1'b1;
      if (sz < 4) return close_block(ST_UNSUPPORTED, r);
      ph = P_SIG;
    end else begin
      if (ph == P_IDLE) return 1'b0;
      pos = pos + 32'd1;
    end
    lst = pos >= sz - 32'd1;
    if (ph == P_NEXT) begin
      if (rcnt >= lim_count) return close_block(ST_LIMIT, r);
      if (sz - pos < 4) begin
        if (lst) return close_block(ST_OK, r);
        ph = P_SKIP;
        return 1'b0;
      end
      sigw = '0; zonly = 1'b1; fl = 32'd4; ph = P_SIG;
    end
    case (ph)
      P_SIG: begin
        sigw = {sigw[23:0], b};
        if (b != 0) zonly = 1'b0;
        fl = fl - 32'd1;
        if (fl != 0) return 1'b0;
        if (pos == 3) begin
          if (sigw != SigWord) return close_block(ST_UNSUPPORTED, r);
          if (lim_block != 0 && sz > lim_block) return close_block(ST_LIMIT, r);
          if (rcnt >= lim_count) return close_block(ST_LIMIT, r);
        end else if (sigw != SigWord) begin
          if (!zonly) return close_block(ST_MALFORMED, r);
          if (lst) return close_block(ST_OK, r);
          ph = P_TRAIL;
          return 1'b0;
        end
        if (lst) return close_block(ST_MALFORMED, r);
        ph = P_ID; fl = 32'd2; idh = '0;
        return 1'b0;
      end
      P_TRAIL: begin
        if (b != 0) return close_block(ST_MALFORMED, r);
        if (lst) return close_block(ST_OK, r);
        return 1'b0;
      end
      P_SKIP: begin
        if (lst) return close_block(ST_OK, r);
        return 1'b0;
      end
      P_ID: begin
        idh = {idh[7:0], b};
        fl = fl - 32'd1;
        if (lst) return close_block(ST_MALFORMED, r);
        if (fl == 0) ph = P_NAMELEN;
        return 1'b0;
      end
      P_NAMELEN: begin
        nt = ({1'b0, b} + 9'd2) & 9'h1FE;
        if ({23'd0, nt} > sz - pos) return close_block(ST_MALFORMED, r);
        fl = {23'd0, nt} - 32'd1;
        ph = P_NAME;
        return 1'b0;
      end
      P_NAME: begin
        fl = fl - 32'd1;
        if (lst) return close_block(ST_MALFORMED, r);
        if (fl == 0) begin
          ph = P_LEN; fl = 32'd4; lenh = '0;
        end
        return 1'b0;
      end
      P_LEN: begin
        lenh = {lenh[23:0], b};
        fl = fl - 32'd1;
        if (fl != 0) begin
          if (lst) return close_block(ST_MALFORMED, r);
          return 1'b0;
        end
        if (lenh > lim_single) return close_block(ST_LIMIT, r);
        padded = ({1'b0, lenh} + 33'd1) & ~33'd1;
        if (padded > {1'b0, sz - pos - 32'd1}) return close_block(ST_MALFORMED, r);
        tot = tot + {32'd0, lenh};
        if (lim_block != 0 && tot > {32'd0, lim_block}) return close_block(ST_LIMIT, r);
        if (lenh == 0) begin
          idx = rcnt[15:0];
          rcnt = rcnt + 17'd1;
          ph = lst ? P_IDLE : P_NEXT;
          r.rsrc_id = idh;
          r.resource_index = idx;
          r.resource_end = 1'b1;
          r.block_done = lst;
          r.status = ST_OK;
          r.resources_done = rcnt;
          return 1'b1;
        end
        doff = '0;
        ph = P_DATA;
        return 1'b0;
      end
      P_DATA: begin
        idx = rcnt[15:0];
        off = doff;
        if (doff == lenh - 32'd1) begin
          rcnt = rcnt + 17'd1;
          ph = lenh[0] ? P_PAD : P_NEXT;
          r.resource_end = 1'b1;
        end
        doff = doff + 32'd1;
        if (lst) ph = P_IDLE;
        r.data_valid = 1'b1;
        r.out_byte = b;
        r.rsrc_id = idh;
        r.resource_index = idx;
        r.byte_offset = off;
        r.block_done = lst;
        r.status = ST_OK;
        r.resources_done = rcnt;
        return 1'b1;
      end
      P_PAD: begin
        if (lst) return close_block(ST_OK, r);
        ph = P_NEXT;
        return 1'b0;
      end
      default: begin
        ph = P_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with none expected, actual %p", $time, got);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    cmp_field("data_valid", want.data_valid, got.data_valid);
    cmp_field("out_byte", want.out_byte, got.out_byte);
    cmp_field("rsrc_id", want.rsrc_id, got.rsrc_id);
    cmp_field("resource_index", want.resource_index, got.resource_index);
    cmp_field("byte_offset", want.byte_offset, got.byte_offset);
    cmp_field("resource_end", want.resource_end, got.resource_end);
    cmp_field("block_done", want.block_done, got.block_done);
    cmp_field("status", want.status, got.status);
    cmp_field("resources_done", want.resources_done, got.resources_done);
  endtask

  // monitor: input and result transactions at the rising edge
  always @(posedge clk_i) begin
    result_t r;
    taken <= rst_ni && push && !full;
    if (rst_ni) begin
      if (push && !full) begin
        if (parse_byte({block_start_i, in_byte_i, block_size_i}, r))
          expected_results.push_back(r);
      end
      if (pop && !empty) check_result(seen);
      if ((pending_bytes.size() != 0 || expected_results.size() != 0) &&
          !(push && !full) && !(pop && !empty))
        stall_cycles++;
      else
        stall_cycles = 0;
      if (stall_cycles >= 5000) begin
        $display("image_resource_block_parser_unit: mismatch");
        $finish;
      end
    end
  end

  // driver for the byte side
  always @(negedge clk_i) begin
    if (taken) void'(pending_bytes.pop_front());
    if (rst_ni && pending_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
      push <= 1'b1;
      {block_start_i, in_byte_i, block_size_i} <= pending_bytes[0];
    end else begin
      push <= 1'b0;
    end
  end

  // result side, with long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_served != hold_req) begin
      hold_served <= hold_req;
      hold_left <= 120;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic add_block(logic [7:0] b[$], logic [31:0] size);
    foreach (b[i]) pending_bytes.push_back({i == 0, b[i], size});
  endtask

  task automatic push_sig(ref logic [7:0] b[$]);
    b.push_back(8'h38); b.push_back(8'h42); b.push_back(8'h49); b.push_back(8'h4D);
  endtask

  task automatic add_random_block(output int n);
    logic [7:0]  b[$];
    logic [31:0] size;
    int          kind, nl, dl, t;
    kind = $urandom_range(0, 19);
    repeat ($urandom_range(1, 3)) begin
      push_sig(b);
      b.push_back(8'($urandom)); b.push_back(8'($urandom));
      nl = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      b.push_back(nl[7:0]);
      repeat (((nl + 2) & ~1) - 1) b.push_back(8'($urandom));
      dl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      b.push_back(dl[31:24]); b.push_back(dl[23:16]); b.push_back(dl[15:8]);
      b.push_back(dl[7:0]);
      repeat (dl) b.push_back(8'($urandom));
      if (dl % 2) b.push_back(8'($urandom));
    end
    t = $urandom_range(0, 5);
    if (t == 0) repeat ($urandom_range(4, 7)) b.push_back(8'h00);
    else if (t == 1) repeat ($urandom_range(1, 3)) b.push_back(8'($urandom));
    else if (t == 2) begin
      repeat (4) b.push_back(8'h00);
      b.push_back(8'($urandom_range(1, 255)));
      b.push_back(8'h00);
    end
    size = b.size();
    if (kind <= 2) b[$urandom_range(0, b.size() - 1)] = 8'($urandom);
    else if (kind == 3) size = b.size() - $urandom_range(1, 4);
    else if (kind == 4) size = b.size() + $urandom_range(1, 3);
    else if (kind == 5) begin
      b.delete();
      repeat ($urandom_range(1, 6)) b.push_back(8'($urandom));
      size = $urandom;
      if (size == 0) size = 1;
    end else if (kind == 6) begin
      pending_bytes.push_back({1'b0, 8'($urandom), 32'($urandom)});
    end
    add_block(b, size);
    n = b.size();
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MAX_COUNT: lim_count = value[16:0];
      REG_MAX_BLOCK: lim_block = value;
      default: lim_single = value;
    endcase
  endtask

  task automatic drain();
    wait (pending_bytes.size() == 0 && expected_results.size() == 0);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] b[$];
    int         n, sent;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // short block, bad signature, stray byte, one resource and a short tail
    add_block({8'h5A}, 32'd3);
    pending_bytes.push_back({1'b0, 8'hFF, 32'hFFFF_FFFF});
    add_block({8'h38, 8'h42, 8'h49, 8'h4E}, 32'd4);
    b = {8'h38, 8'h42, 8'h49, 8'h4D, 8'hFF, 8'hFF, 8'h00, 8'h00,
         8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'hAA, 8'h00, 8'h00};
    add_block(b, 32'd17);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        1: begin
          write_reg(REG_MAX_COUNT, 32'h1FFFF);
          write_reg(REG_MAX_BLOCK, 32'hFFFF_FFFF);
          write_reg(REG_MAX_SINGLE, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(REG_MAX_COUNT, 32'd0);
          write_reg(REG_MAX_BLOCK, 32'd0);
          write_reg(REG_MAX_SINGLE, 32'd0);
        end
        3: begin
          write_reg(REG_MAX_COUNT, 32'd1);
          write_reg(REG_MAX_BLOCK, 32'd24);
          write_reg(REG_MAX_SINGLE, 32'd3);
        end
        4: begin
          write_reg(REG_MAX_COUNT, 32'd2);
          write_reg(REG_MAX_BLOCK, 32'd0);
          write_reg(REG_MAX_SINGLE, 32'd6);
        end
        5: begin
          write_reg(REG_MAX_COUNT, $urandom_range(0, 4));
          write_reg(REG_MAX_BLOCK, $urandom_range(0, 60));
          write_reg(REG_MAX_SINGLE, $urandom_range(0, 9));
        end
        default: ;
      endcase
      send_idle = (p < 2) ? 14 : (p < 4) ? 80 : 0;
      recv_idle = (p < 2) ? 80 : (p < 4) ? 14 : 0;
      if (p == 1 || p == 4) hold_req++;
      sent = 0;
      while (sent < 155) begin
        add_random_block(n);
        sent += n;
      end
      // close any open block before the next register change
      add_block({8'h00}, 32'd3);
    end

    drain();
    if (errors == 0) begin
      $display("image_resource_block_parser_unit: match");
    end else begin
      $display("image_resource_block_parser_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/irbp_pkg.sv
src/irbp_fifo.sv
src/irbp_engine.sv
src/image_resource_block_parser_unit.sv
test/tb.sv
